[sv/packet_delay_jitter_loss_emulator_top_macros.svh]
// ----------------------------------------------------------------------------
// Packet delay, jitter and loss emulator: assertion macros
// Checks that are compiled for simulation and left empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PACKET_DELAY_JITTER_LOSS_EMULATOR_TOP_MACROS_SVH
`define PACKET_DELAY_JITTER_LOSS_EMULATOR_TOP_MACROS_SVH
`ifndef SYNTH
`define PDJLE_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pdjle: invariant violated");
`define PDJLE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdjle: next-cycle check failed");
`else
`define PDJLE_ASSERT_ALWAYS(label, expr)
`define PDJLE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/pdjle_pkg.sv]
// ----------------------------------------------------------------------------
// Packet delay, jitter and loss emulator: package
// Sizes, codes, item types and the control interface of the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdjle_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = PTR_W + 1;
    localparam int QLIM_W      = 8;
    localparam int LIM_W       = (CNT_W > QLIM_W) ? CNT_W : QLIM_W;

    localparam int TIME_W      = 32;
    localparam int HANDLE_W    = 16;
    localparam int JIT_W       = 16;
    localparam int LOSS_W      = 7;
    localparam int OC_W        = 2;
    localparam int DIV_STEP_W  = $clog2(JIT_W);
    localparam int J_W         = TIME_W + 3;
    localparam int AVG_W       = 32;
    localparam int AVG15_W     = AVG_W + 5;
    localparam int ACC_W       = J_W + 9;
    localparam int ENTRY_W     = HANDLE_W + TIME_W;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLED      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JITTER_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_PERCENT = 3'd4;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_TICK    = 1'b1;

    localparam logic [OC_W-1:0] OC_DELIVERED = 2'd0;
    localparam logic [OC_W-1:0] OC_LOST      = 2'd1;
    localparam logic [OC_W-1:0] OC_DROPPED   = 2'd2;

    typedef struct packed {
        logic                func;
        logic [TIME_W-1:0]   now;
        logic [HANDLE_W-1:0] handle;
        logic [JIT_W-1:0]    rand_jitter;
        logic [LOSS_W-1:0]   rand_loss;
    } in_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] out_handle;
        logic [TIME_W-1:0]   release_time;
        logic [OC_W-1:0]     outcome;
    } out_item_t;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic jit_calc;
        logic tick_take;
        logic pass_load;
        logic drop_take;
        logic pop;
        logic rd_tail;
        logic tail_chk;
        logic write;
        logic avg_upd;
        logic out_load;
    } pdjle_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic enabled;
        logic fill_zero;
        logic over_limit;
        logic head_due;
        logic div_done;
        logic out_free;
    } pdjle_sts_t;

endpackage

`default_nettype wire

[sv/pdjle_ram.sv]
// ----------------------------------------------------------------------------
// Packet delay, jitter and loss emulator: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdjle_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[sv/pdjle_div.sv]
// ----------------------------------------------------------------------------
// Packet delay, jitter and loss emulator: serial remainder unit
// Restoring division, one dividend bit per cycle, giving the remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdjle_div
    import pdjle_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [JIT_W-1:0] dividend,
    input  logic [JIT_W-1:0] divisor,
    output logic             busy,
    output logic [JIT_W-1:0] rem
);

    logic                  busy_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [JIT_W-1:0]      quo_reg;
    logic [JIT_W-1:0]      rem_reg;
    logic [JIT_W-1:0]      div_reg;
    logic [JIT_W:0]        trial;
    logic [JIT_W:0]        rem_next;

    assign trial    = {rem_reg, quo_reg[JIT_W-1]};
    assign rem_next = (trial >= {1'b0, div_reg}) ? trial - {1'b0, div_reg} : trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= DIV_STEP_W'(JIT_W - 1);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[JIT_W-2:0], 1'b0};
            rem_reg <= rem_next[JIT_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

[sv/pdjle_ctrl.sv]
// ----------------------------------------------------------------------------
// Packet delay, jitter and loss emulator: controller
// Sequences one item at a time through the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "packet_delay_jitter_loss_emulator_top_macros.svh"

module pdjle_ctrl
    import pdjle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  pdjle_sts_t sts,
    output pdjle_cmd_t cmd
);

    typedef enum logic [12:0] {
        S_IDLE       = 13'b0000000000001,
        S_DECODE     = 13'b0000000000010,
        S_TICK_CHK   = 13'b0000000000100,
        S_DIV        = 13'b0000000001000,
        S_JIT        = 13'b0000000010000,
        S_DROP_FIRST = 13'b0000000100000,
        S_DROP_TAKE  = 13'b0000001000000,
        S_DROP_MORE  = 13'b0000010000000,
        S_TAIL       = 13'b0000100000000,
        S_TAIL_CHK   = 13'b0001000000000,
        S_WRITE      = 13'b0010000000000,
        S_AVG        = 13'b0100000000000,
        S_OUT        = 13'b1000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   has_res_reg;
    logic   has_res_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_tick)
                begin
                    state_next = (sts.enabled && !sts.fill_zero) ? S_TICK_CHK : S_IDLE;
                end
                else if (!sts.enabled)
                begin
                    cmd.pass_load = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_TICK_CHK:
            begin
                if (sts.head_due)
                begin
                    cmd.tick_take = 1'b1;
                    cmd.pop       = 1'b1;
                    state_next    = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_JIT;
                end
            end
            S_JIT:
            begin
                cmd.jit_calc = 1'b1;
                state_next   = S_DROP_FIRST;
            end
            S_DROP_FIRST:
            begin
                state_next = sts.over_limit ? S_DROP_TAKE : S_TAIL;
            end
            S_DROP_TAKE:
            begin
                cmd.drop_take = 1'b1;
                cmd.pop       = 1'b1;
                state_next    = S_DROP_MORE;
            end
            S_DROP_MORE:
            begin
                if (sts.over_limit)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                cmd.rd_tail = 1'b1;
                state_next  = S_TAIL_CHK;
            end
            S_TAIL_CHK:
            begin
                cmd.tail_chk = 1'b1;
                state_next   = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_AVG;
            end
            S_AVG:
            begin
                cmd.avg_upd = 1'b1;
                state_next  = has_res_reg ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        has_res_next = has_res_reg;
        if (cmd.out_load)
        begin
            has_res_next = 1'b0;
        end
        else if (cmd.tick_take || cmd.pass_load || cmd.drop_take)
        begin
            has_res_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            has_res_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            has_res_reg <= has_res_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    `PDJLE_ASSERT_NEXT(a_accept_decodes, in_valid && !in_stall, state_reg == S_DECODE)
    `PDJLE_ASSERT_ALWAYS(a_out_has_result, state_reg != S_OUT || has_res_reg)
    `PDJLE_ASSERT_NEXT(a_div_waits, state_reg == S_DIV && !sts.div_done, state_reg == S_DIV)

endmodule

`default_nettype wire

[sv/pdjle_dp.sv]
// ----------------------------------------------------------------------------
// Packet delay, jitter and loss emulator: datapath
// Configuration, packet ring, jitter arithmetic, average and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "packet_delay_jitter_loss_emulator_top_macros.svh"

module pdjle_dp
    import pdjle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  pdjle_cmd_t            cmd,
    output pdjle_sts_t            sts
);

    logic                     cfg_enabled_reg;
    logic [JIT_W-1:0]         cfg_base_reg;
    logic [JIT_W-1:0]         cfg_jmax_reg;
    logic [QLIM_W-1:0]        cfg_qlim_reg;
    logic [LOSS_W-1:0]        cfg_loss_reg;

    in_item_t                 in_reg;
    logic [TIME_W:0]          nominal_reg;
    logic signed [J_W-1:0]    j_reg;
    logic [TIME_W-1:0]        t_reg;
    logic signed [AVG_W-1:0]  avg_reg;
    logic signed [AVG15_W-1:0] avg15_reg;
    logic [PTR_W-1:0]         head_reg;
    logic [CNT_W-1:0]         fill_reg;
    out_item_t                res_reg;
    out_item_t                out_reg;
    logic                     out_valid_reg;

    logic                     div_busy;
    logic [JIT_W-1:0]         div_rem;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic [PTR_W-1:0]         ram_raddr;
    logic [HANDLE_W-1:0]      ram_handle;
    logic [TIME_W-1:0]        ram_time;

    logic                     jit_on;
    logic [LIM_W-1:0]         qlim_ext;
    logic [CNT_W-1:0]         limit;
    logic [PTR_W-1:0]         head_inc;
    logic [SUM_W-1:0]         tail_sum;
    logic [SUM_W-1:0]         pos_sum;
    logic [PTR_W-1:0]         tail_idx;
    logic [PTR_W-1:0]         pos_idx;
    logic signed [J_W-1:0]    jm_s;
    logic signed [J_W-1:0]    base_s;
    logic signed [J_W-1:0]    j_sel;
    logic [TIME_W-1:0]        t_sel;
    logic signed [J_W-1:0]    j_tail;
    logic signed [AVG15_W-1:0] avg_ext;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  acc_q;
    logic signed [AVG_W-1:0]  avg_next;
    logic [OC_W-1:0]          loss_oc;
    logic                     out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_enabled_reg <= 1'b1;
            cfg_base_reg    <= '0;
            cfg_jmax_reg    <= '0;
            cfg_qlim_reg    <= '0;
            cfg_loss_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ENABLED:      cfg_enabled_reg <= cfg_wdata[0];
                REG_BASE_DELAY:   cfg_base_reg    <= cfg_wdata[JIT_W-1:0];
                REG_JITTER_MAX:   cfg_jmax_reg    <= cfg_wdata[JIT_W-1:0];
                REG_QUEUE_LIMIT:  cfg_qlim_reg    <= cfg_wdata[QLIM_W-1:0];
                REG_LOSS_PERCENT: cfg_loss_reg    <= cfg_wdata[LOSS_W-1:0];
                default:          ;
            endcase
        end
    end

    pdjle_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (in_reg.rand_jitter),
        .divisor  (cfg_jmax_reg),
        .busy     (div_busy),
        .rem      (div_rem)
    );

    pdjle_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.write),
        .waddr (pos_idx),
        .wdata ({in_reg.handle, t_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_handle = ram_rdata[ENTRY_W-1:TIME_W];
    assign ram_time   = ram_rdata[TIME_W-1:0];

    assign jit_on   = (cfg_jmax_reg != '0);
    assign qlim_ext = LIM_W'(cfg_qlim_reg);
    assign limit    = (cfg_qlim_reg == '0 || qlim_ext > LIM_W'(QUEUE_DEPTH))
                      ? CNT_W'(QUEUE_DEPTH) : CNT_W'(qlim_ext);

    assign head_inc = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg) - 1'b1;
    assign pos_sum  = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_idx = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                      ? PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign pos_idx  = (pos_sum >= SUM_W'(QUEUE_DEPTH))
                      ? PTR_W'(pos_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(pos_sum);
    assign ram_raddr = cmd.rd_tail ? tail_idx : head_reg;

    // While the average is positive the draw is turned negative, but never below
    // minus the base delay.
    assign jm_s   = signed'({{(J_W - JIT_W){1'b0}}, div_rem});
    assign base_s = signed'({{(J_W - JIT_W){1'b0}}, cfg_base_reg});
    always_comb
    begin
        if (!jit_on)
        begin
            j_sel = '0;
        end
        else if (avg_reg > 32'sd0)
        begin
            j_sel = (cfg_base_reg > div_rem) ? -jm_s : -base_s;
        end
        else
        begin
            j_sel = jm_s;
        end
    end
    assign t_sel  = nominal_reg[TIME_W-1:0] + j_sel[TIME_W-1:0];
    assign j_tail = signed'({3'b000, ram_time}) - signed'({2'b00, nominal_reg});

    assign avg_ext = signed'({{(AVG15_W - AVG_W){avg_reg[AVG_W-1]}}, avg_reg});
    assign acc     = signed'({{(ACC_W - AVG15_W){avg15_reg[AVG15_W-1]}}, avg15_reg})
                   + signed'({j_reg[J_W-1], j_reg, 8'b0});
    assign acc_q   = acc >>> 4;
    always_comb
    begin
        if (acc_q > signed'(ACC_W'(32'sh7fffffff)))
        begin
            avg_next = 32'sh7fffffff;
        end
        else if (acc_q < -signed'(ACC_W'(64'sh80000000)))
        begin
            avg_next = -32'sh7fffffff - 32'sd1;
        end
        else
        begin
            avg_next = acc_q[AVG_W-1:0];
        end
    end

    assign loss_oc = (cfg_loss_reg != '0 && in_reg.rand_loss <= cfg_loss_reg)
                     ? OC_LOST : OC_DELIVERED;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg      <= in_data;
            nominal_reg <= {1'b0, in_data.now} + {{(TIME_W + 1 - JIT_W){1'b0}}, cfg_base_reg};
        end
        if (cmd.jit_calc)
        begin
            j_reg <= j_sel;
            t_reg <= t_sel;
        end
        else if (cmd.tail_chk && fill_reg != '0 && ram_time > t_reg)
        begin
            j_reg <= j_tail;
            t_reg <= ram_time;
        end
        if (cmd.write)
        begin
            avg15_reg <= (avg_ext <<< 4) - avg_ext;
        end
        if (cmd.pass_load)
        begin
            res_reg <= '{out_handle: in_reg.handle, release_time: in_reg.now,
                         outcome: OC_DELIVERED};
        end
        else if (cmd.tick_take)
        begin
            res_reg <= '{out_handle: ram_handle, release_time: ram_time, outcome: loss_oc};
        end
        else if (cmd.drop_take)
        begin
            res_reg <= '{out_handle: ram_handle, release_time: ram_time, outcome: OC_DROPPED};
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            fill_reg      <= '0;
            avg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.pop)
            begin
                head_reg <= head_inc;
                fill_reg <= fill_reg - 1'b1;
            end
            else if (cmd.write)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.avg_upd && jit_on)
            begin
                avg_reg <= avg_next;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign sts.is_tick    = (in_reg.func == FUNC_TICK);
    assign sts.enabled    = cfg_enabled_reg;
    assign sts.fill_zero  = (fill_reg == '0);
    assign sts.over_limit = (fill_reg >= limit) && (fill_reg != '0);
    assign sts.head_due   = (ram_time <= in_reg.now);
    assign sts.div_done   = !div_busy;
    assign sts.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `PDJLE_ASSERT_ALWAYS(a_fill_bound, fill_reg <= CNT_W'(QUEUE_DEPTH))
    `PDJLE_ASSERT_NEXT(a_write_grows, cmd.write, fill_reg == $past(fill_reg) + 1'b1)
    `PDJLE_ASSERT_NEXT(a_out_hold, out_valid_reg && out_stall, out_valid_reg && $stable(out_reg))

endmodule

`default_nettype wire

[sv/packet_delay_jitter_loss_emulator_top.sv]
// ----------------------------------------------------------------------------
// Packet delay, jitter and loss emulator: top level
// Network impairment model holding packets for a base delay plus jitter.
// ----------------------------------------------------------------------------
// Input items on in_valid/in_stall carry either a packet arrival or a time
// tick; result items leave on out_valid/out_stall. An arrival while enabled
// queues the packet and gives a result only when the queue limit forces the
// oldest packet out. A tick releases the head packet once it is due, marking
// it delivered or lost. A disabled block passes an arrival straight out.
// The block takes one item at a time, paced by the controller. An enabled
// arrival waits on the serial remainder unit that draws the jitter; one that
// drops entries pops the first in S_DROP_TAKE and any further in S_DROP_MORE.
// After reset the queue is empty, the average is zero and the block is
// enabled with all other settings zero. While the receiver stalls the output
// register holds its item, and an item with a result waits for it to free.
`timescale 1ns / 1ps
`default_nettype none

module packet_delay_jitter_loss_emulator_top
    import pdjle_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    pdjle_cmd_t cmd;
    pdjle_sts_t sts;

    pdjle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    pdjle_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
